// ===== src/lr4_pkg.sv =====
// ----------------------------------------------------------------------------
// lr4_pkg: shared types and constants
// Register indexes, sequencer states and fixed widths of the high-pass mixer.
// ----------------------------------------------------------------------------
package lr4_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned StateW  = 32;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned AccW    = 72;

  localparam logic [2:0] RegB0   = 3'd0;
  localparam logic [2:0] RegB1   = 3'd1;
  localparam logic [2:0] RegB2   = 3'd2;
  localparam logic [2:0] RegA1   = 3'd3;
  localparam logic [2:0] RegA2   = 3'd4;
  localparam logic [2:0] RegGain = 3'd5;
  localparam logic [2:0] RegMix  = 3'd6;

  localparam logic [23:0] GainReset = 24'd1048576;
  localparam logic [23:0] MixUnity  = 24'd8388608;

  typedef enum logic [1:0] {
    OP_SET,
    OP_ADD,
    OP_SUB
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_Y,
    ST_A_N1,
    ST_A_N2,
    ST_B_Y,
    ST_B_N1,
    ST_B_N2,
    ST_GAIN,
    ST_MIX,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic           start;
    mac_op_t        op;
    logic signed [StateW:0] mult;
  } mac_cmd_t;

endpackage

// ===== src/lr4_serial_mac.sv =====
// ----------------------------------------------------------------------------
// lr4_serial_mac: bit-serial multiply-accumulate
// Multiplies a signed 40-bit operand by a signed 33-bit multiplier one bit
// per cycle and adds or subtracts the product into a 72-bit accumulator.
// ----------------------------------------------------------------------------
module lr4_serial_mac
  import lr4_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_cmd_t                cmd,
  input  logic signed [39:0]      mcand,
  input  logic signed [AccW-1:0]  acc_init,
  output logic signed [AccW-1:0]  acc,
  output logic                    busy
);

  localparam int unsigned MultW = StateW + 1;

  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [AccW-1:0] sh_r, sh_nxt;
  logic [MultW-1:0]       mb_r, mb_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mb_nxt   = mb_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      acc_nxt  = (cmd.op == OP_SET) ? '0 : acc_init;
      sh_nxt   = AccW'(mcand);
      mb_nxt   = cmd.mult;
      neg_nxt  = (cmd.op == OP_SUB);
      cnt_nxt  = 6'(MultW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mb_r[0]) begin
        // The top multiplier bit carries negative weight.
        if ((cnt_r == 6'd1) ^ neg_r) begin
          acc_nxt = acc_r - sh_r;
        end else begin
          acc_nxt = acc_r + sh_r;
        end
      end
      sh_nxt  = sh_r <<< 1;
      mb_nxt  = mb_r >> 1;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
  end

  assign acc  = acc_r;
  assign busy = busy_r;

  always @(posedge clk) begin
    if (rst_n && busy_r && cnt_r == 6'd0) begin
      $error("mac busy with no bits left");
    end
  end

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) cmd.start |=> busy_r;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("mac did not start");

  property p_count_down;
    @(posedge clk) disable iff (!rst_n)
      (busy_r && !cmd.start) |=> (cnt_r == $past(cnt_r) - 6'd1);
  endproperty
  a_count_down: assert property (p_count_down) else $error("mac count skipped");

  property p_done;
    @(posedge clk) disable iff (!rst_n)
      (busy_r && cnt_r == 6'd1 && !cmd.start) |=> !busy_r;
  endproperty
  a_done: assert property (p_done) else $error("mac overran");

endmodule

// ===== src/lr4_highpass_mix_core.sv =====
// ----------------------------------------------------------------------------
// lr4_highpass_mix_core: fourth-order Linkwitz-Riley high-pass with gain/mix
// Two cascaded TDF-II biquads per TDM channel, gain and dry/wet mix.
// Each beat runs 13 serial multiplies through the single bit-serial multiplier,
// and its result is registered at the output once the output is free.
// in_stall holds off a new beat until the current result is handed on.
// A channel beyond CHANNELS skips the filters and passes its input sample through.
// Reset clears all channel delay state and loads default register values.
// ----------------------------------------------------------------------------
module lr4_highpass_mix_core
  import lr4_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ChanW-1:0]         in_channel,
  input  logic signed [SampleW-1:0] in_sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SampleW-1:0] out_sample_out,
  output logic [ChanW-1:0]         out_channel_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [23:0]              cfg_data
);

  localparam int unsigned SlotW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [CoefW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [23:0]             gain_r, mix_r;

  logic signed [StateW-1:0] za1_r [CHANNELS];
  logic signed [StateW-1:0] za2_r [CHANNELS];
  logic signed [StateW-1:0] zb1_r [CHANNELS];
  logic signed [StateW-1:0] zb2_r [CHANNELS];

  seq_state_t st_r, st_nxt;
  logic       pend_r;
  logic [ChanW-1:0] ch_r;
  logic signed [SampleW-1:0] x_r;
  logic signed [StateW-1:0] u_r, y_r, n1_r;
  logic signed [AccW-1:0]   hold_r;
  logic                     out_valid_r;
  logic signed [SampleW-1:0] out_s_r;
  logic [ChanW-1:0]         out_c_r;

  mac_cmd_t mcmd;
  logic signed [39:0]     mcand;
  logic signed [AccW-1:0] macc, acc_init;
  logic                   mbusy;
  logic                   in_acc, hit;
  logic [SlotW-1:0]       slot;
  logic [23:0]            w;

  mac_cmd_t mcmd2;
  logic signed [39:0] mcand2;
  logic two_step, sec_go_r, fin;
  logic signed [StateW-1:0] z1_sel, z2_sel;
  logic signed [AccW-1:0]   sh22;
  mac_cmd_t mcmd_mux;
  logic signed [39:0] mcand_mux;
  logic sec_start;

  assign hit    = (32'(ch_r) < CHANNELS);
  assign slot   = SlotW'(ch_r);
  assign in_acc = in_valid && !in_stall;
  assign w      = (mix_r > MixUnity) ? MixUnity : mix_r;

  function automatic logic signed [StateW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v > AccW'(64'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (v < -AccW'(64'sh80000000)) begin
      return 32'sh80000000;
    end
    return v[StateW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [AccW-1:0] v);
    if (v > AccW'(64'sh7FFFFF)) begin
      return 24'sh7FFFFF;
    end else if (v < -AccW'(64'sh800000)) begin
      return 24'sh800000;
    end
    return v[SampleW-1:0];
  endfunction

  lr4_serial_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mcmd_mux),
    .mcand    (mcand_mux),
    .acc_init (acc_init),
    .acc      (macc),
    .busy     (mbusy)
  );

  // Each state runs one or two multiplies; pend_r marks the state's multiplies as under way.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_A_Y;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        if (!hit) begin
          st_nxt = ST_DONE;
        end else if (fin) begin
          st_nxt = seq_state_t'(st_r + 4'd1);
        end
      end
    endcase
  end

  // Multiply commands: multiplier is the 33-bit operand, mcand the coefficient (the gained sample in ST_MIX).
  always_comb begin
    mcmd.start = 1'b0;
    mcmd.op    = OP_SET;
    mcmd.mult  = '0;
    mcand      = '0;
    acc_init   = macc;
    if (hit && !mbusy && !pend_r) begin
      mcmd.start = (st_r != ST_IDLE) && (st_r != ST_DONE);
    end
    case (st_r)
      ST_A_Y, ST_B_Y: begin
        mcand     = 40'(b0_r);
        mcmd.mult = 33'(u_r);
      end
      ST_A_N1, ST_B_N1: begin
        mcand     = 40'(b1_r);
        mcmd.mult = 33'(u_r);
      end
      ST_A_N2, ST_B_N2: begin
        mcand     = 40'(b2_r);
        mcmd.mult = 33'(u_r);
      end
      ST_GAIN: begin
        mcand     = 40'($signed({1'b0, gain_r}));
        mcmd.mult = 33'(y_r);
      end
      ST_MIX: begin
        mcand     = 40'(hold_r);
        mcmd.mult = 33'($signed({1'b0, w}));
      end
      default: begin
        mcand = '0;
      end
    endcase
  end

  // Second multiply of a state, issued from the sequencer below.
  always_comb begin
    mcmd2.start = 1'b0;
    mcmd2.op    = OP_SUB;
    mcmd2.mult  = 33'(y_r);
    mcand2      = '0;
    case (st_r)
      ST_A_N1, ST_B_N1: mcand2 = 40'(a1_r);
      ST_A_N2, ST_B_N2: mcand2 = 40'(a2_r);
      ST_MIX: begin
        mcmd2.op   = OP_ADD;
        mcmd2.mult = 33'(x_r);
        mcand2     = 40'($signed({1'b0, 24'(MixUnity - w)}));
      end
      default: mcand2 = '0;
    endcase
  end

  assign two_step = (st_r == ST_A_N1) || (st_r == ST_A_N2) || (st_r == ST_B_N1)
                    || (st_r == ST_B_N2) || (st_r == ST_MIX);

  // sec_go_r: second product runs; fin: all products of this state are in.
  assign fin = pend_r && !mbusy && !mcmd.start && (!two_step || sec_go_r);

  assign z1_sel = (st_r <= ST_A_N2) ? za1_r[slot] : zb1_r[slot];
  assign z2_sel = (st_r <= ST_A_N2) ? za2_r[slot] : zb2_r[slot];
  assign sh22   = macc >>> 22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pend_r      <= 1'b0;
      sec_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      b0_r <= '0; b1_r <= '0; b2_r <= '0; a1_r <= '0; a2_r <= '0;
      gain_r <= GainReset;
      mix_r  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        za1_r[i] <= '0; za2_r[i] <= '0; zb1_r[i] <= '0; zb2_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegB0:   b0_r   <= cfg_data;
          RegB1:   b1_r   <= cfg_data;
          RegB2:   b2_r   <= cfg_data;
          RegA1:   a1_r   <= cfg_data;
          RegA2:   a2_r   <= cfg_data;
          RegGain: gain_r <= cfg_data;
          RegMix:  mix_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        ch_r <= in_channel;
        x_r  <= in_sample_in;
        u_r  <= 32'(in_sample_in);
      end
      if (mcmd.start) begin
        pend_r   <= 1'b1;
        sec_go_r <= 1'b0;
      end else if (pend_r && !mbusy && two_step && !sec_go_r) begin
        sec_go_r <= 1'b1;
      end
      st_r <= st_nxt;
      if (st_r == ST_DONE && st_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
        out_c_r     <= ch_r;
        out_s_r     <= hit ? sat24(hold_r) : x_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fin) begin
        pend_r   <= 1'b0;
        sec_go_r <= 1'b0;
        case (st_r)
          ST_A_Y, ST_B_Y: y_r <= sat32(sh22 + AccW'(z1_sel));
          ST_A_N1, ST_B_N1: n1_r <= sat32(sh22 + AccW'(z2_sel));
          ST_A_N2: begin
            za1_r[slot] <= n1_r;
            za2_r[slot] <= sat32(sh22);
            u_r         <= y_r;
          end
          ST_B_N2: begin
            zb1_r[slot] <= n1_r;
            zb2_r[slot] <= sat32(sh22);
          end
          ST_GAIN: hold_r <= macc >>> 20;
          ST_MIX:  hold_r <= macc >>> 23;
          default: ;
        endcase
      end
    end
  end

  // The second product shares the unit through a separate start path.
  assign sec_start = pend_r && !mbusy && two_step && !sec_go_r && !mcmd.start;
  always_comb begin
    mcmd_mux  = sec_start ? mcmd2 : mcmd;
    mcand_mux = sec_start ? mcand2 : mcand;
    mcmd_mux.start = mcmd.start || sec_start;
  end

  assign in_stall        = (st_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_s_r;
  assign out_channel_out = out_c_r;

endmodule
